### rtl/ambient_light_level_filter_assert.svh
// Assertion macros used by the top level of the ambient light filter RTL.
`ifndef AMBIENT_LIGHT_LEVEL_FILTER_ASSERT_SVH
`define AMBIENT_LIGHT_LEVEL_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on i_clk, off during reset
`define ALF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// next-cycle implication, checked on i_clk, off during reset
`define ALF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define ALF_ASSERT_NOW(label, ante, cons)
`define ALF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/alf_pkg.sv
// Shared types and constants of the ambient light level filter.
`timescale 1ns / 1ps
package alf_pkg;

    localparam int WINDOW      = 8;
    localparam int SAMPLE_BITS = 12;
    localparam int VALUE_W     = 12;
    localparam int LEVEL_W     = 3;
    localparam int HOLD_W      = 6;
    localparam int REP_W       = 8;
    localparam int STABLE_W    = 7;
    localparam int CNT_W       = $clog2(WINDOW);
    localparam int SUM_W       = SAMPLE_BITS + $clog2(WINDOW);
    localparam int DIV         = WINDOW - 2;
    localparam int RECIP_W     = SUM_W + 1;

    localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(WINDOW - 1);
    localparam logic [SUM_W-1:0]   DIV_V    = SUM_W'(DIV);
    // floor(2^SUM_W / DIV); the quotient it gives is low by at most one
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'((64'd1 << SUM_W) / DIV);

    localparam logic [VALUE_W-1:0] RST_ZERO_LIMIT = 12'd26;
    localparam logic [HOLD_W-1:0]  RST_HOLD       = 6'd14;
    localparam logic [VALUE_W-1:0] RST_EDGE_0     = 12'd86;
    localparam logic [VALUE_W-1:0] RST_EDGE_1     = 12'd430;
    localparam logic [VALUE_W-1:0] RST_EDGE_2     = 12'd1104;
    localparam logic [VALUE_W-1:0] RST_EDGE_3     = 12'd1643;

    localparam logic [LEVEL_W-1:0] LEVEL_TOP = 3'd4;

    typedef enum logic [2:0] {
        REG_ZERO_LIMIT = 3'd0,
        REG_HOLD_COUNT = 3'd1,
        REG_EDGE_0     = 3'd2,
        REG_EDGE_1     = 3'd3,
        REG_EDGE_2     = 3'd4,
        REG_EDGE_3     = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TRIM,
        ST_MUL,
        ST_CHK,
        ST_FIX,
        ST_POST
    } t_state;

    typedef struct packed {
        logic [VALUE_W-1:0]           zero_limit;
        logic [HOLD_W-1:0]            hold_count;
        logic [3:0][VALUE_W-1:0]      level_edge;
    } t_cfg;

    typedef struct packed {
        logic fill;   // load the input sample
        logic shift;  // take the neighbor's data
    } t_cell_ctrl;

    typedef struct packed {
        logic scan_first;
        logic scan;
        logic trim;
        logic mul;
        logic chk;
        logic fix;
    } t_mean_ctrl;

endpackage

### rtl/alf_cell.sv
// One window cell: holds a sample and passes it along the ring.
`timescale 1ns / 1ps
module alf_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  alf_pkg::t_cell_ctrl                 i_ctrl,
    input  logic [alf_pkg::SAMPLE_BITS-1:0]     i_sample,
    input  logic [alf_pkg::SAMPLE_BITS-1:0]     i_neighbor,
    output logic [alf_pkg::SAMPLE_BITS-1:0]     o_data
);

    logic [alf_pkg::SAMPLE_BITS-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            priority if (i_ctrl.fill) begin
                r_data <= i_sample;
            end else if (i_ctrl.shift) begin
                r_data <= i_neighbor;
            end else begin
                // hold
                r_data <= r_data;
            end
        end
    end

    assign o_data = r_data;

endmodule

### rtl/alf_mean.sv
// Trimmed mean: serial sum, max and min, then divide by a constant.
`timescale 1ns / 1ps
module alf_mean (
    input  logic                                i_clk,
    input  alf_pkg::t_mean_ctrl                 i_ctrl,
    input  logic [alf_pkg::SAMPLE_BITS-1:0]     i_data,
    output logic [alf_pkg::VALUE_W-1:0]         o_mean
);

    localparam int SW = alf_pkg::SUM_W;
    localparam int PW = 2 * SW + 1;

    logic [SW-1:0]                     r_sum;
    logic [alf_pkg::SAMPLE_BITS-1:0]   r_hi;
    logic [alf_pkg::SAMPLE_BITS-1:0]   r_lo;
    logic [SW-1:0]                     r_num;
    logic [SW-1:0]                     r_q0;
    logic [SW-1:0]                     r_rem;
    logic [alf_pkg::VALUE_W-1:0]       r_mean;
    logic [PW-1:0]                     w_prod;
    logic [SW-1:0]                     w_back;
    logic [SW-1:0]                     w_data;

    assign w_data = SW'(i_data);
    assign w_prod = PW'(r_num) * PW'(alf_pkg::RECIP);
    assign w_back = SW'(r_q0 * alf_pkg::DIV_V);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.scan) begin
            if (i_ctrl.scan_first) begin
                r_sum <= w_data;
                r_hi  <= i_data;
                r_lo  <= i_data;
            end else begin
                r_sum <= r_sum + w_data;
                if (i_data > r_hi) begin
                    r_hi <= i_data;
                end
                if (i_data < r_lo) begin
                    r_lo <= i_data;
                end
            end
        end
        if (i_ctrl.trim) begin
            r_num <= r_sum - SW'(r_hi) - SW'(r_lo);
        end
        if (i_ctrl.mul) begin
            r_q0 <= w_prod[2*SW-1:SW];
        end
        if (i_ctrl.chk) begin
            r_rem <= r_num - w_back;
        end
        // remainder stays below twice the divisor: one correction step
        if (i_ctrl.fix) begin
            r_mean <= alf_pkg::VALUE_W'(r_q0 + SW'(r_rem >= alf_pkg::DIV_V));
        end
    end

    assign o_mean = r_mean;

endmodule

### rtl/alf_track.sv
// Dark-level fix and level debounce state of the light filter.
`timescale 1ns / 1ps
module alf_track (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  alf_pkg::t_cfg                    i_cfg,
    input  logic                             i_clear,
    input  logic                             i_update,
    input  logic [alf_pkg::VALUE_W-1:0]      i_mean,
    output logic [alf_pkg::VALUE_W-1:0]      o_value,
    output logic [alf_pkg::LEVEL_W-1:0]      o_level,
    output logic                             o_emit
);

    logic [alf_pkg::VALUE_W-1:0]  r_prev,   n_prev;
    logic [alf_pkg::REP_W-1:0]    r_rep,    n_rep;
    logic [alf_pkg::VALUE_W-1:0]  r_shift,  n_shift;
    logic                         r_active, n_active;
    logic [alf_pkg::LEVEL_W-1:0]  r_cur,    n_cur;
    logic [alf_pkg::STABLE_W-1:0] r_stable, n_stable;

    logic [alf_pkg::VALUE_W-1:0]  w_val;
    logic [alf_pkg::LEVEL_W-1:0]  w_lvl;
    logic                         w_emit;
    logic                         w_near;

    assign w_near = i_mean <= i_cfg.zero_limit;

    always_comb begin
        n_prev   = r_prev;
        n_rep    = r_rep;
        n_shift  = r_shift;
        n_active = r_active;
        n_cur    = r_cur;
        n_stable = r_stable;
        w_emit   = 1'b0;
        w_val    = i_mean;

        if ((r_prev == i_mean) && w_near) begin
            if (r_rep != '1) begin
                n_rep = r_rep + 1'b1;
            end
            // latch after twice the hold count of repeats
            if ((r_rep == {1'b0, i_cfg.hold_count, 1'b0}) && !r_active) begin
                n_shift  = i_mean;
                n_active = 1'b1;
                n_rep    = '0;
            end
        end else if (!w_near) begin
            n_active = 1'b0;
        end
        if (n_active) begin
            w_val = n_shift;
            if (n_shift != '0) begin
                n_shift = n_shift - 1'b1;
            end
        end
        n_prev = w_val;

        priority if (w_val <= i_cfg.level_edge[0]) begin
            w_lvl = 3'd0;
        end else if (w_val <= i_cfg.level_edge[1]) begin
            w_lvl = 3'd1;
        end else if (w_val <= i_cfg.level_edge[2]) begin
            w_lvl = 3'd2;
        end else if (w_val <= i_cfg.level_edge[3]) begin
            w_lvl = 3'd3;
        end else begin
            w_lvl = alf_pkg::LEVEL_TOP;
        end

        if (r_cur == w_lvl) begin
            n_stable = r_stable + 1'b1;
            if (r_stable == {1'b0, i_cfg.hold_count}) begin
                n_stable = '0;
                w_emit   = 1'b1;
            end
        end else begin
            n_cur    = w_lvl;
            n_stable = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_prev   <= '0;
            r_rep    <= '0;
            r_shift  <= '0;
            r_active <= 1'b0;
            r_cur    <= '0;
            r_stable <= '0;
        end else if (i_update) begin
            r_prev   <= n_prev;
            r_rep    <= n_rep;
            r_shift  <= n_shift;
            r_active <= n_active;
            r_cur    <= n_cur;
            r_stable <= n_stable;
        end
    end

    assign o_value = w_val;
    assign o_level = w_lvl;
    assign o_emit  = w_emit;

endmodule

### rtl/ambient_light_level_filter.sv
// Top level of the ambient light level filter: control, window ring, config port.
//
// Input channel (i_in_valid / o_in_stall) carries one ADC sample per beat with a
// first-sample flag; a flagged sample refills the whole window and clears the
// dark-fix and debounce state. The window is a ring of WINDOW cells that
// rotates once per cycle during the scan past a serial sum/max/min unit, so
// a sample is scanned over every cell and then passes trim, multiply, check,
// fix and update before the next accept. o_in_stall is high while a sample
// is at work, and is low only while the block is idle.
// Output channel (o_out_valid / i_out_stall) carries zero or one beat per
// sample: the filtered value and its level, loaded into an output register
// on the update cycle. A held result does not block the next sample; only
// the update cycle waits while the output register is still full and stalled.
// Config is an APB-style port, registers at byte address 4*index, pready
// tied high; write only while the block is idle.
// Reset (i_rst_n low, synchronous) clears the window to zero, restores the
// register defaults and empties the output register.
`timescale 1ns / 1ps
`include "ambient_light_level_filter_assert.svh"
module ambient_light_level_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_first_sample,
    input  logic [alf_pkg::SAMPLE_BITS-1:0]     i_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [alf_pkg::VALUE_W-1:0]         o_light_value,
    output logic [alf_pkg::LEVEL_W-1:0]         o_light_level,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [4:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    alf_pkg::t_state                   r_state, n_state;
    logic [alf_pkg::CNT_W-1:0]         r_cnt,   n_cnt;
    alf_pkg::t_cfg                     r_cfg;
    logic                              r_out_valid;
    logic [alf_pkg::VALUE_W-1:0]       r_value;
    logic [alf_pkg::LEVEL_W-1:0]       r_level;

    logic                              w_accept;
    logic                              w_out_free;
    logic                              w_update;
    logic                              w_cfg_wr;
    alf_pkg::t_reg_idx                 w_idx;
    alf_pkg::t_cell_ctrl               w_cell_ctrl;
    alf_pkg::t_mean_ctrl               w_mean_ctrl;
    logic [alf_pkg::SAMPLE_BITS-1:0]   w_cell [alf_pkg::WINDOW];
    logic [alf_pkg::SAMPLE_BITS-1:0]   w_head;
    logic [alf_pkg::VALUE_W-1:0]       w_mean;
    logic [alf_pkg::VALUE_W-1:0]       w_value;
    logic [alf_pkg::LEVEL_W-1:0]       w_level;
    logic                              w_emit;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            alf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = alf_pkg::ST_SCAN;
                    n_cnt   = '0;
                end
            end
            alf_pkg::ST_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == alf_pkg::CNT_LAST) begin
                    n_state = alf_pkg::ST_TRIM;
                    n_cnt   = '0;
                end
            end
            alf_pkg::ST_TRIM: n_state = alf_pkg::ST_MUL;
            alf_pkg::ST_MUL:  n_state = alf_pkg::ST_CHK;
            alf_pkg::ST_CHK:  n_state = alf_pkg::ST_FIX;
            alf_pkg::ST_FIX:  n_state = alf_pkg::ST_POST;
            alf_pkg::ST_POST: begin
                if (w_out_free) begin
                    n_state = alf_pkg::ST_IDLE;
                end
            end
            default: n_state = alf_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall             = 1'b1;
        w_update               = 1'b0;
        w_mean_ctrl            = '0;
        unique case (r_state)
            alf_pkg::ST_IDLE: o_in_stall = 1'b0;
            alf_pkg::ST_SCAN: begin
                w_mean_ctrl.scan       = 1'b1;
                w_mean_ctrl.scan_first = (r_cnt == '0);
            end
            alf_pkg::ST_TRIM: w_mean_ctrl.trim = 1'b1;
            alf_pkg::ST_MUL:  w_mean_ctrl.mul  = 1'b1;
            alf_pkg::ST_CHK:  w_mean_ctrl.chk  = 1'b1;
            alf_pkg::ST_FIX:  w_mean_ctrl.fix  = 1'b1;
            alf_pkg::ST_POST: w_update = w_out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    always_comb begin
        w_cell_ctrl.fill  = w_accept && i_first_sample;
        w_cell_ctrl.shift = (w_accept && !i_first_sample) || w_mean_ctrl.scan;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= alf_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // window ring: new sample enters cell 0, scan rotates the last cell back in
    assign w_head = w_mean_ctrl.scan ? w_cell[alf_pkg::WINDOW-1] : i_sample;

    for (genvar g = 0; g < alf_pkg::WINDOW; g++) begin : g_cell
        alf_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_cell_ctrl),
            .i_sample   (i_sample),
            .i_neighbor ((g == 0) ? w_head : w_cell[(g == 0) ? 0 : g - 1]),
            .o_data     (w_cell[g])
        );
    end

    alf_mean u_mean (
        .i_clk  (i_clk),
        .i_ctrl (w_mean_ctrl),
        .i_data (w_cell[alf_pkg::WINDOW-1]),
        .o_mean (w_mean)
    );

    alf_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_clear  (w_cell_ctrl.fill),
        .i_update (w_update),
        .i_mean   (w_mean),
        .o_value  (w_value),
        .o_level  (w_level),
        .o_emit   (w_emit)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_update && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_update && w_emit) begin
            r_value <= w_value;
            r_level <= w_level;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_light_value = r_value;
    assign o_light_level = r_level;

    // config registers
    assign pready   = 1'b1;
    assign w_idx    = alf_pkg::t_reg_idx'(paddr[4:2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_limit    <= alf_pkg::RST_ZERO_LIMIT;
            r_cfg.hold_count    <= alf_pkg::RST_HOLD;
            r_cfg.level_edge[0] <= alf_pkg::RST_EDGE_0;
            r_cfg.level_edge[1] <= alf_pkg::RST_EDGE_1;
            r_cfg.level_edge[2] <= alf_pkg::RST_EDGE_2;
            r_cfg.level_edge[3] <= alf_pkg::RST_EDGE_3;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                alf_pkg::REG_ZERO_LIMIT: r_cfg.zero_limit    <= pwdata[11:0];
                alf_pkg::REG_HOLD_COUNT: r_cfg.hold_count    <= pwdata[5:0];
                alf_pkg::REG_EDGE_0:     r_cfg.level_edge[0] <= pwdata[11:0];
                alf_pkg::REG_EDGE_1:     r_cfg.level_edge[1] <= pwdata[11:0];
                alf_pkg::REG_EDGE_2:     r_cfg.level_edge[2] <= pwdata[11:0];
                alf_pkg::REG_EDGE_3:     r_cfg.level_edge[3] <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            alf_pkg::REG_ZERO_LIMIT: prdata = {20'd0, r_cfg.zero_limit};
            alf_pkg::REG_HOLD_COUNT: prdata = {26'd0, r_cfg.hold_count};
            alf_pkg::REG_EDGE_0:     prdata = {20'd0, r_cfg.level_edge[0]};
            alf_pkg::REG_EDGE_1:     prdata = {20'd0, r_cfg.level_edge[1]};
            alf_pkg::REG_EDGE_2:     prdata = {20'd0, r_cfg.level_edge[2]};
            alf_pkg::REG_EDGE_3:     prdata = {20'd0, r_cfg.level_edge[3]};
            default:                 prdata = '0;
        endcase
    end

    `ALF_ASSERT_NEXT(a_accept_starts_scan, w_accept, w_mean_ctrl.scan_first)
    `ALF_ASSERT_NEXT(a_scan_length, w_mean_ctrl.scan && r_cnt == alf_pkg::CNT_LAST, w_mean_ctrl.trim)
    `ALF_ASSERT_NEXT(a_post_stall, r_state == alf_pkg::ST_POST && !w_out_free, $stable(r_state))
    `ALF_ASSERT_NOW(a_level_range, o_out_valid, o_light_level <= alf_pkg::LEVEL_TOP)

endmodule

### dv/ambient_light_level_filter_tb.sv
// Self-checking testbench for the ambient light level filter: predictor, driver, monitor.
`timescale 1ns / 1ps
module ambient_light_level_filter_tb;
    import alf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 24;

    typedef struct packed {
        logic                   first;
        logic [SAMPLE_BITS-1:0] sample;
    } sample_beat_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [LEVEL_W-1:0] level;
    } light_report_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic                   i_first_sample;
    logic [SAMPLE_BITS-1:0] i_sample;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [VALUE_W-1:0]     o_light_value;
    logic [LEVEL_W-1:0]     o_light_level;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [4:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    ambient_light_level_filter uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_first_sample (i_first_sample),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_light_value  (o_light_value),
        .o_light_level  (o_light_level),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // register shadow
    logic [VALUE_W-1:0] cfg_zero_limit;
    logic [HOLD_W-1:0]  cfg_hold;
    logic [VALUE_W-1:0] cfg_edge [4];

    // filter state shadow
    logic [SAMPLE_BITS-1:0] win [WINDOW];
    logic [CNT_W-1:0]       wslot;
    logic [VALUE_W-1:0]     prev_val;
    logic [REP_W-1:0]       rep_cnt;
    logic [VALUE_W-1:0]     shift_val;
    logic                   fix_on;
    logic [LEVEL_W-1:0]     cur_lvl;
    logic [STABLE_W-1:0]    stable_cnt;

    sample_beat_t  sample_q[$];
    light_report_t light_reports_q[$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  phase_items    = 0;
    int  idle_pct       = 0;
    bit  calm           = 1'b0;
    bit  sender_paused  = 1'b0;
    int  hold_requests  = 0;
    int  hold_served    = 0;
    int  long_left      = 0;
    int  stall_left     = 0;
    int  gap_left       = 0;
    sample_beat_t  nxt;
    light_report_t want;

    // One tick of the filter; queue a report when the level debounce fires.
    function automatic void filter_sample(input logic first, input logic [SAMPLE_BITS-1:0] s);
        int unsigned        sum;
        logic [VALUE_W-1:0] hi;
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] v;
        logic [LEVEL_W-1:0] lv;
        logic [CNT_W-1:0]   slot;
        int                 old_rep;
        int                 old_st;
        slot = wslot;
        wslot = (int'(wslot) == WINDOW - 1) ? '0 : wslot + 1'b1;
        if (first) begin
            for (int k = 0; k < WINDOW; k++) win[k] = s;
            prev_val   = '0;
            rep_cnt    = '0;
            shift_val  = '0;
            fix_on     = 1'b0;
            cur_lvl    = '0;
            stable_cnt = '0;
        end else begin
            win[slot] = s;
        end

        sum = 0;
        hi  = win[0];
        lo  = win[0];
        for (int k = 0; k < WINDOW; k++) begin
            sum += win[k];
            if (win[k] > hi) hi = win[k];
            if (win[k] < lo) lo = win[k];
        end
        v = VALUE_W'((sum - hi - lo) / (WINDOW - 2));

        // dark-level fix
        if (prev_val == v && v <= cfg_zero_limit) begin
            old_rep = int'(rep_cnt);
            if (rep_cnt != '1) rep_cnt = rep_cnt + 1'b1;
            if (old_rep == 2 * int'(cfg_hold) && !fix_on) begin
                shift_val = v;
                fix_on    = 1'b1;
                rep_cnt   = '0;
            end
        end else if (v > cfg_zero_limit) begin
            fix_on = 1'b0;
        end
        if (fix_on) begin
            v = shift_val;
            if (shift_val != '0) shift_val = shift_val - 1'b1;
        end
        prev_val = v;

        // first edge not exceeded wins
        lv = LEVEL_TOP;
        for (int k = 3; k >= 0; k--) begin
            if (v <= cfg_edge[k]) lv = LEVEL_W'(k);
        end

        if (cur_lvl == lv) begin
            old_st = int'(stable_cnt);
            stable_cnt = stable_cnt + 1'b1;
            if (old_st == int'(cfg_hold)) begin
                stable_cnt = '0;
                light_reports_q.push_back('{value: v, level: lv});
            end
        end else begin
            cur_lvl    = lv;
            stable_cnt = '0;
        end
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid     <= 1'b0;
            i_first_sample <= 1'b0;
            i_sample       <= '0;
            gap_left        = 0;
        end else begin
            if (i_in_valid && !o_in_stall) filter_sample(i_first_sample, i_sample);
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (sample_q.size() != 0 && !sender_paused) begin
                    nxt = sample_q.pop_front();
                    i_in_valid     <= 1'b1;
                    i_first_sample <= nxt.first;
                    i_sample       <= nxt.sample;
                    if (!calm && idle_pct != 0 && $urandom_range(99) < idle_pct)
                        gap_left = $urandom_range(7, 1);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall: short random bursts, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left   = 0;
            long_left    = 0;
        end else begin
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                long_left   = LONG_HOLD;
            end
            if (long_left > 0) begin
                long_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!calm && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                stall_left = $urandom_range(6, 0);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (light_reports_q.size() == 0) begin
                $error("light_value: expected none, got %0d (level %0d)",
                       o_light_value, o_light_level);
                mismatch_count++;
            end else begin
                want = light_reports_q.pop_front();
                if (o_light_value !== want.value) begin
                    $error("light_value: expected %0d, got %0d", want.value, o_light_value);
                    mismatch_count++;
                end
                if (o_light_level !== want.level) begin
                    $error("light_level: expected %0d, got %0d", want.level, o_light_level);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic cfg_write(input t_reg_idx idx, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ZERO_LIMIT: cfg_zero_limit = data[VALUE_W-1:0];
            REG_HOLD_COUNT: cfg_hold       = data[HOLD_W-1:0];
            REG_EDGE_0:     cfg_edge[0]    = data[VALUE_W-1:0];
            REG_EDGE_1:     cfg_edge[1]    = data[VALUE_W-1:0];
            REG_EDGE_2:     cfg_edge[2]    = data[VALUE_W-1:0];
            REG_EDGE_3:     cfg_edge[3]    = data[VALUE_W-1:0];
            default: ;
        endcase
    endtask

    // junk in the upper data bits must be dropped by the block
    task automatic set_config(input int zl, input int hold,
                              input int e0, input int e1, input int e2, input int e3);
        logic [31:0] junk;
        junk = $urandom();
        cfg_write(REG_ZERO_LIMIT, {junk[31:12], 12'(zl)});
        cfg_write(REG_HOLD_COUNT, {junk[25:0], 6'(hold)});
        cfg_write(REG_EDGE_0, {junk[19:0], 12'(e0)});
        cfg_write(REG_EDGE_1, {junk[31:12], 12'(e1)});
        cfg_write(REG_EDGE_2, {junk[27:8], 12'(e2)});
        cfg_write(REG_EDGE_3, {junk[23:4], 12'(e3)});
    endtask

    function automatic void queue_sample(input bit first, input int s);
        if (s < 0) s = 0;
        if (s > 4095) s = 4095;
        sample_q.push_back('{first: first, sample: SAMPLE_BITS'(s)});
        phase_items++;
    endfunction

    // Well-formed runs (steady levels, dark repeats) with some noise between them.
    task automatic queue_run(input bit allow_first);
        int kind;
        int len;
        int base;
        int amp;
        int lim;
        bit first;
        kind  = $urandom_range(99);
        first = allow_first && ($urandom_range(3) == 0);
        if (kind < 40) begin
            case ($urandom_range(3))
                0: base = int'(cfg_edge[$urandom_range(3)]) + $urandom_range(4) - 2;
                1: base = $urandom_range(4095);
                2: base = $urandom_range(60);
                default: base = 4095 - $urandom_range(3);
            endcase
            len = $urandom_range(2 * int'(cfg_hold) + 20, 1);
            amp = $urandom_range(3);
            for (int i = 0; i < len; i++)
                queue_sample(first && i == 0, base + $urandom_range(2 * amp) - amp);
        end else if (kind < 70) begin
            lim  = (cfg_zero_limit < 60) ? int'(cfg_zero_limit) : 60;
            base = $urandom_range(lim);
            len  = 2 * int'(cfg_hold) + $urandom_range(40, 1);
            for (int i = 0; i < len; i++) queue_sample(first && i == 0, base);
        end else begin
            len = $urandom_range(8, 1);
            for (int i = 0; i < len; i++)
                queue_sample($urandom_range(9) == 0, $urandom_range(4095));
        end
    endtask

    task automatic wait_idle();
        while (sample_q.size() != 0 || i_in_valid || o_in_stall || light_reports_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int e0;
        int e1;
        int e2;
        int e3;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_first_sample = 1'b0;
        i_sample       = '0;
        i_out_stall    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cfg_zero_limit = RST_ZERO_LIMIT;
        cfg_hold       = RST_HOLD;
        cfg_edge[0]    = RST_EDGE_0;
        cfg_edge[1]    = RST_EDGE_1;
        cfg_edge[2]    = RST_EDGE_2;
        cfg_edge[3]    = RST_EDGE_3;
        for (int k = 0; k < WINDOW; k++) win[k] = '0;
        wslot      = '0;
        prev_val   = '0;
        rep_cnt    = '0;
        shift_val  = '0;
        fix_on     = 1'b0;
        cur_lvl    = '0;
        stable_cnt = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats at reset settings: full-scale refill, ring wrap,
        // top level, all bits toggled, values on both sides of edges
        idle_pct = 20;
        queue_sample(1'b1, 4095);
        for (int i = 0; i < 8; i++) queue_sample(1'b0, 4095);
        queue_sample(1'b1, 0);
        for (int i = 0; i < 3; i++) queue_sample(1'b0, 0);
        queue_sample(1'b0, 'hAAA);
        queue_sample(1'b0, 'h555);
        queue_sample(1'b1, 86);
        queue_sample(1'b0, 87);
        queue_sample(1'b1, 1643);
        queue_sample(1'b0, 1644);
        queue_sample(1'b1, 430);
        queue_sample(1'b0, 1104);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_config(26, 14, 86, 430, 1104, 1643);
                1: set_config(4095, 0, 0, 0, 0, 0);
                2: set_config(0, 63, 4095, 4095, 4095, 4095);
                3: set_config(200, 3, 1000, 300, 3000, 2000);
                5: set_config(60, 1, 100, 800, 1500, 3000);
                7: set_config(26, 5, 86, 430, 1104, 1643);
                default: begin
                    e0 = $urandom_range(500);
                    e1 = e0 + $urandom_range(800);
                    e2 = e1 + $urandom_range(1000);
                    e3 = e2 + $urandom_range(1000);
                    set_config($urandom_range(400), $urandom_range(10), e0, e1, e2, e3);
                end
            endcase
            calm     = (ph == 7);
            idle_pct = calm ? 0 : (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 15 : 40;
            phase_items = 0;
            // long dark stretch: latch, count down to zero, saturate the repeat count
            if (ph == 0) begin
                queue_sample(1'b1, 0);
                for (int i = 0; i < 300; i++) queue_sample(1'b0, 0);
            end
            // keep the first run flag-free so the stable count carries over
            queue_run(1'b0);
            while (phase_items < 100) queue_run(1'b1);
            if (ph == 3) hold_requests++;
            if (ph == 4) begin
                while (sample_q.size() > phase_items / 2) @(posedge i_clk);
                sender_paused = 1'b1;
                while (i_in_valid || o_in_stall || light_reports_q.size() != 0)
                    @(posedge i_clk);
                sender_paused = 1'b0;
            end
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/alf_pkg.sv
rtl/alf_cell.sv
rtl/alf_mean.sv
rtl/alf_track.sv
rtl/ambient_light_level_filter.sv
dv/ambient_light_level_filter_tb.sv
